// ===== rtl/scc_pkg.sv =====
`default_nettype none

package scc_pkg;

   localparam int GRID_SIDE   = 256;
   localparam int HALF_WINDOW = 6;
   localparam int WIN_SIZE    = 2 * HALF_WINDOW + 1;

   localparam int COORD_W   = 8;
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int GRID_AW   = $clog2(GRID_SIDE);

   localparam int SIZE_A = (COORD_W + 1 > CSR_W) ? COORD_W + 1 : CSR_W;
   localparam int SIZE_W = (SIZE_A > GRID_AW + 1) ? SIZE_A : GRID_AW + 1;

   localparam int ROW_CNT_W = $clog2(WIN_SIZE + 1);
   localparam int D_W       = COORD_W + 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = CSR_IDX_W'(1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_BOUNDS,
      ST_SCAN,
      ST_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               row_clr;
      logic               bit_wr;
      logic [GRID_AW-1:0] row;
      logic [GRID_AW-1:0] col;
      logic               bit_val;
   } grid_wr_type;

endpackage

`default_nettype wire

// ===== rtl/scc_grid.sv =====
`default_nettype none

module scc_grid import scc_pkg::*; (
   input  wire logic                 clock,
   input  wire grid_wr_type          wr,
   input  wire logic [GRID_AW-1:0]   rd_row,
   output logic      [GRID_SIDE-1:0] rd_data
);

   logic [GRID_SIDE-1:0] mem [GRID_SIDE];
   logic [GRID_SIDE-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.row_clr) begin
         mem[wr.row] <= '0;
      end else if (wr.bit_wr) begin
         mem[wr.row][wr.col] <= wr.bit_val;
      end
      rd_data_ff <= mem[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/segment_clearance_check_top.sv =====
// Write item: accepted while idle, no result; busy stays low.
// Check item: each of the N line points gets a bounds test and a scan of its 13-cell window,
// ending early when a point is out of bounds or a window fails.
// The scan reads one grid row per cycle through the single registered row port.
// Reset: synchronous; busy stays high while all GRID_SIDE rows are cleared.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module segment_clearance_check_top import scc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_operation,
   input  wire logic [COORD_W-1:0]   req_write_x,
   input  wire logic [COORD_W-1:0]   req_write_y,
   input  wire logic                 req_write_free,
   input  wire logic [COORD_W-1:0]   req_start_x,
   input  wire logic [COORD_W-1:0]   req_start_y,
   input  wire logic [COORD_W-1:0]   req_end_x,
   input  wire logic [COORD_W-1:0]   req_end_y,
   output logic                      rsp_valid,
   output logic                      rsp_path_clear,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [SIZE_W-1:0]    GRID_S = SIZE_W'(GRID_SIDE);
   localparam logic [SIZE_W-1:0]    HW_S   = SIZE_W'(HALF_WINDOW);
   localparam logic [ROW_CNT_W-1:0] ROW_LAST = ROW_CNT_W'(WIN_SIZE);

   state_type state_ff, state_in;
   logic [GRID_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [CSR_W-1:0]     map_w_ff, map_h_ff;
   logic [COORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic                 neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [COORD_W-1:0]   major_ff, major_in, minor_ff, minor_in;
   logic                 major_x_ff, major_x_in;
   logic signed [D_W-1:0] d_ff, d_in;
   logic [COORD_W-1:0]   step_ff, step_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic                 pass_ff, pass_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_clear_ff, rsp_clear_in;

   logic [SIZE_W-1:0]    w_eff, h_eff, x_s, y_s, col_lo, rd_row_s;
   logic [SIZE_W-1:0]    map_w_s, map_h_s, wr_x_s, wr_y_s;
   logic                 in_bounds, issue, scan_fail, win_ok;
   logic [GRID_SIDE-1:0] rd_data, row_shift;
   logic [WIN_SIZE-1:0]  win_bits;
   logic [COORD_W:0]     dx_raw, dy_raw;
   logic [COORD_W-1:0]   adx, ady, big, small_len;
   logic signed [D_W-1:0] two_small, big_s, two_minor, two_major;
   logic [COORD_W-1:0]   x_step, y_step;
   logic                 accept;
   grid_wr_type          grid_wr;

   scc_grid u_grid (
      .clock   (clock),
      .wr      (grid_wr),
      .rd_row  (rd_row_s[GRID_AW-1:0]),
      .rd_data (rd_data)
   );

   assign accept  = start && (state_ff == ST_IDLE);
   assign map_w_s = SIZE_W'(map_w_ff);
   assign map_h_s = SIZE_W'(map_h_ff);
   assign w_eff   = (map_w_s > GRID_S) ? GRID_S : map_w_s;
   assign h_eff   = (map_h_s > GRID_S) ? GRID_S : map_h_s;
   assign x_s     = SIZE_W'(x_ff);
   assign y_s     = SIZE_W'(y_ff);
   assign wr_x_s  = SIZE_W'(req_write_x);
   assign wr_y_s  = SIZE_W'(req_write_y);

   assign in_bounds = (x_s >= HW_S) && (x_s + HW_S < w_eff)
                   && (y_s >= HW_S) && (y_s + HW_S < h_eff);

   assign col_lo    = x_s - HW_S;
   assign rd_row_s  = y_s - HW_S + SIZE_W'(row_ff);
   assign row_shift = rd_data >> col_lo;
   assign win_bits  = row_shift[WIN_SIZE-1:0];
   assign win_ok    = &win_bits;
   assign issue     = row_ff < ROW_LAST;
   assign scan_fail = chk_vld_ff && !win_ok;

   assign dx_raw = {1'b0, req_end_x} - {1'b0, req_start_x};
   assign dy_raw = {1'b0, req_end_y} - {1'b0, req_start_y};
   assign adx    = dx_raw[COORD_W] ? COORD_W'(-dx_raw) : dx_raw[COORD_W-1:0];
   assign ady    = dy_raw[COORD_W] ? COORD_W'(-dy_raw) : dy_raw[COORD_W-1:0];

   // in SETUP major_ff holds |dx| and minor_ff holds |dy|
   assign big       = (major_ff > minor_ff) ? major_ff : minor_ff;
   assign small_len = (major_ff > minor_ff) ? minor_ff : major_ff;
   assign two_small = signed'(D_W'({small_len, 1'b0}));
   assign big_s     = signed'(D_W'(big));
   assign two_minor = signed'(D_W'({minor_ff, 1'b0}));
   assign two_major = signed'(D_W'({major_ff, 1'b0}));
   assign x_step    = neg_x_ff ? x_ff - COORD_W'(1) : x_ff + COORD_W'(1);
   assign y_step    = neg_y_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      major_x_in = major_x_ff;
      d_in       = d_ff;
      step_in    = step_ff;
      row_in     = row_ff;
      pass_in    = pass_ff;
      chk_vld_in = (state_ff == ST_SCAN) && issue;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + GRID_AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_operation == OP_CHECK) begin
               x_in     = req_start_x;
               y_in     = req_start_y;
               neg_x_in = dx_raw[COORD_W];
               neg_y_in = dy_raw[COORD_W];
               major_in = adx;
               minor_in = ady;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            major_x_in = major_ff > minor_ff;
            major_in   = big;
            minor_in   = small_len;
            d_in       = two_small - big_s;
            step_in    = '0;
            state_in   = ST_BOUNDS;
         end
         ST_BOUNDS: begin
            if (!in_bounds) begin
               pass_in  = 1'b0;
               state_in = ST_DONE;
            end else begin
               row_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_fail) begin
               pass_in  = 1'b0;
               state_in = ST_DONE;
            end else if (row_ff == ROW_LAST) begin
               state_in = ST_STEP;
            end else begin
               row_in = row_ff + ROW_CNT_W'(1);
            end
         end
         ST_STEP: begin
            if (step_ff == major_ff) begin
               pass_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + COORD_W'(1);
               if (major_x_ff) begin
                  x_in = x_step;
               end else begin
                  y_in = y_step;
               end
               if (d_ff < 0) begin
                  d_in = d_ff + two_minor;
               end else begin
                  d_in = d_ff + two_minor - two_major;
                  if (major_x_ff) begin
                     y_in = y_step;
                  end else begin
                     x_in = x_step;
                  end
               end
               state_in = ST_BOUNDS;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy           = (state_ff != ST_IDLE);
      rsp_valid_in   = (state_ff == ST_DONE);
      rsp_clear_in   = pass_ff;
      grid_wr.row_clr = (state_ff == ST_CLEAR);
      grid_wr.bit_wr  = accept && (req_operation == OP_WRITE)
                     && (wr_x_s < GRID_S) && (wr_y_s < GRID_S);
      grid_wr.row     = (state_ff == ST_CLEAR) ? clr_cnt_ff : wr_y_s[GRID_AW-1:0];
      grid_wr.col     = wr_x_s[GRID_AW-1:0];
      grid_wr.bit_val = req_write_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_w_ff <= CSR_W'(GRID_SIDE);
         map_h_ff <= CSR_W'(GRID_SIDE);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_w_ff <= csr_wdata;
            CSR_MAP_HEIGHT: map_h_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      major_ff     <= major_in;
      minor_ff     <= minor_in;
      major_x_ff   <= major_x_in;
      d_ff         <= d_in;
      step_ff      <= step_in;
      row_ff       <= row_in;
      pass_ff      <= pass_in;
      rsp_clear_ff <= rsp_clear_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_clear = rsp_clear_ff;

endmodule

`default_nettype wire

// ===== rtl/scc_checker.sv =====
`default_nettype none

module scc_checker import scc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_operation,
   input wire logic rsp_valid
);

   // clear rows after reset before taking items
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_WRITE) |=> (!busy && !rsp_valid))
      else $error("write item did not finish in one cycle or gave a result");

   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_CHECK) |=> busy)
      else $error("check item did not raise busy");

endmodule

bind segment_clearance_check_top scc_checker u_scc_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
   import scc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 40;
   localparam int QUIET_LIMIT   = 20000;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] write_x;
      logic [COORD_W-1:0] write_y;
      logic               write_free;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } grid_cmd_type;

   typedef enum logic {ROW_CMD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      grid_cmd_type         cmd;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CSR_W-1:0]     csr_val;
      bit                   known;
      bit                   answer;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_operation = OP_WRITE;
   logic [COORD_W-1:0]   req_write_x = '0;
   logic [COORD_W-1:0]   req_write_y = '0;
   logic                 req_write_free = 1'b0;
   logic [COORD_W-1:0]   req_start_x = '0;
   logic [COORD_W-1:0]   req_start_y = '0;
   logic [COORD_W-1:0]   req_end_x = '0;
   logic [COORD_W-1:0]   req_end_y = '0;
   logic                 rsp_valid;
   logic                 rsp_path_clear;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   segment_clearance_check_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit               free_cell [GRID_SIDE*GRID_SIDE];
   logic [CSR_W-1:0] map_cols = CSR_W'(GRID_SIDE);
   logic [CSR_W-1:0] map_rows = CSR_W'(GRID_SIDE);
   bit               clear_expected [$];
   plan_row_type     plan_rows [$];
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               sent_count = 0;
   bit               burst = 1'b0;
   int               reg_x, reg_y, reg_w, reg_h;

   function automatic void append_answer(bit v);
      clear_expected.insert(clear_expected.size(), v);
   endfunction

   function automatic void append_row(plan_row_type r);
      plan_rows.insert(plan_rows.size(), r);
   endfunction

   function automatic int clip_size(logic [CSR_W-1:0] r);
      return (r > GRID_SIDE) ? GRID_SIDE : int'(r);
   endfunction

   function automatic bit window_free(int cx, int cy, int w, int h);
      int x, y;
      for (int dy = -HALF_WINDOW; dy <= HALF_WINDOW; dy++) begin
         for (int dx = -HALF_WINDOW; dx <= HALF_WINDOW; dx++) begin
            x = cx + dx;
            y = cy + dy;
            if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
            if (!free_cell[y * GRID_SIDE + x]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit segment_free(grid_cmd_type c);
      int w, h, x, y, adx, ady, sx, sy, err;
      w = clip_size(map_cols);
      h = clip_size(map_rows);
      x = int'(c.start_x);
      y = int'(c.start_y);
      adx = int'(c.end_x) - x;
      ady = int'(c.end_y) - y;
      sx = (adx < 0) ? -1 : 1;
      sy = (ady < 0) ? -1 : 1;
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      if (!window_free(x, y, w, h)) return 1'b0;
      if (adx > ady) begin
         err = 2 * ady - adx;
         repeat (adx) begin
            x += sx;
            if (err < 0) begin
               err += 2 * ady;
            end else begin
               y += sy;
               err += 2 * ady - 2 * adx;
            end
            if (!window_free(x, y, w, h)) return 1'b0;
         end
      end else begin
         err = 2 * adx - ady;
         repeat (ady) begin
            y += sy;
            if (err < 0) begin
               err += 2 * adx;
            end else begin
               x += sx;
               err += 2 * adx - 2 * ady;
            end
            if (!window_free(x, y, w, h)) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic grid_cmd_type random_cmd();
      grid_cmd_type c;
      c.operation  = OP_WRITE;
      c.write_x    = COORD_W'($urandom);
      c.write_y    = COORD_W'($urandom);
      c.write_free = 1'($urandom);
      c.start_x    = COORD_W'($urandom);
      c.start_y    = COORD_W'($urandom);
      c.end_x      = COORD_W'($urandom);
      c.end_y      = COORD_W'($urandom);
      return c;
   endfunction

   function automatic plan_row_type chk_row(int sx, int sy, int ex, int ey, bit known,
                                            bit answer);
      plan_row_type r;
      r = '0;
      r.kind           = ROW_CMD;
      r.cmd.operation  = OP_CHECK;
      r.cmd.start_x    = COORD_W'(sx);
      r.cmd.start_y    = COORD_W'(sy);
      r.cmd.end_x      = COORD_W'(ex);
      r.cmd.end_y      = COORD_W'(ey);
      r.cmd.write_x    = ~COORD_W'(sx);
      r.cmd.write_y    = ~COORD_W'(sy);
      r.cmd.write_free = 1'b1;
      r.known          = known;
      r.answer         = answer;
      return r;
   endfunction

   function automatic plan_row_type wr_row(int x, int y, bit free_bit);
      plan_row_type r;
      r = '0;
      r.kind           = ROW_CMD;
      r.cmd.operation  = OP_WRITE;
      r.cmd.write_x    = COORD_W'(x);
      r.cmd.write_y    = COORD_W'(y);
      r.cmd.write_free = free_bit;
      r.cmd.start_x    = COORD_W'(x);
      r.cmd.start_y    = COORD_W'(y);
      r.cmd.end_x      = ~COORD_W'(x);
      r.cmd.end_y      = ~COORD_W'(y);
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_W-1:0] idx, int val);
      plan_row_type r;
      r = '0;
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = CSR_W'(val);
      return r;
   endfunction

   function automatic int edge_or_any(int side);
      case ($urandom_range(0, 2))
         0: return 0;
         1: return GRID_SIDE - side;
         default: return $urandom_range(0, GRID_SIDE - side);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] near_center(int origin, int side, int margin);
      int lo, hi;
      lo = origin + HALF_WINDOW - margin;
      hi = origin + side - 1 - HALF_WINDOW + margin;
      if (lo < 0) lo = 0;
      if (hi > GRID_SIDE - 1) hi = GRID_SIDE - 1;
      return COORD_W'($urandom_range(lo, hi));
   endfunction

   task automatic send_cmd(grid_cmd_type c, bit known, bit answer);
      int gap;
      sent_count++;
      if (sent_count % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = $urandom_range(0, 99);
      if (burst || gap < 50) gap = 0;
      else if (gap < 85) gap = $urandom_range(1, 3);
      else if (gap < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      repeat (gap) @(negedge clock) start <= 1'b0;
      @(negedge clock);
      start          <= 1'b1;
      req_operation  <= c.operation;
      req_write_x    <= c.write_x;
      req_write_y    <= c.write_y;
      req_write_free <= c.write_free;
      req_start_x    <= c.start_x;
      req_start_y    <= c.start_y;
      req_end_x      <= c.end_x;
      req_end_y      <= c.end_y;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (c.operation == OP_WRITE)
         free_cell[int'(c.write_y) * GRID_SIDE + int'(c.write_x)] = c.write_free;
      else
         append_answer(known ? answer : segment_free(c));
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      start <= 1'b0;
      while (clear_expected.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAP_WIDTH) map_cols = val;
      else if (idx == CSR_MAP_HEIGHT) map_rows = val;
   endtask

   task automatic carve_region(int x0, int y0, int w, int h);
      grid_cmd_type c;
      reg_x = x0;
      reg_y = y0;
      reg_w = w;
      reg_h = h;
      for (int y = y0; y < y0 + h; y++) begin
         for (int x = x0; x < x0 + w; x++) begin
            c = random_cmd();
            c.operation  = OP_WRITE;
            c.write_x    = COORD_W'(x);
            c.write_y    = COORD_W'(y);
            c.write_free = 1'b1;
            send_cmd(c, 1'b0, 1'b0);
         end
      end
   endtask

   task automatic run_mixed(int n);
      grid_cmd_type c;
      int pick, margin;
      repeat (n) begin
         c = random_cmd();
         pick = $urandom_range(0, 99);
         margin = ($urandom_range(0, 3) == 0) ? 2 : 0;
         if (pick < 60) begin
            c.operation = OP_CHECK;
            c.start_x = near_center(reg_x, reg_w, margin);
            c.start_y = near_center(reg_y, reg_h, margin);
            c.end_x   = near_center(reg_x, reg_w, margin);
            c.end_y   = near_center(reg_y, reg_h, margin);
         end else if (pick < 75) begin
            c.operation  = OP_WRITE;
            c.write_x    = COORD_W'($urandom_range(reg_x, reg_x + reg_w - 1));
            c.write_y    = COORD_W'($urandom_range(reg_y, reg_y + reg_h - 1));
            c.write_free = ($urandom_range(0, 3) != 0);
         end else if (pick < 88) begin
            c.operation = OP_CHECK;
         end
         send_cmd(c, 1'b0, 1'b0);
      end
   endtask

   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid) begin
         if (clear_expected.size() == 0) begin
            $error("path_clear result %0b with no check item waiting", rsp_path_clear);
            mismatches++;
         end else begin
            want = clear_expected.pop_front();
            if (rsp_path_clear !== want) begin
               $error("path_clear expected %0b actual %0b", want, rsp_path_clear);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || csr_we || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int w0, h0;

      append_row(chk_row(0, 0, 255, 255, 1'b1, 1'b0));
      append_row(chk_row(128, 128, 128, 128, 1'b1, 1'b0));
      append_row(wr_row(255, 255, 1'b1));
      append_row(wr_row(0, 0, 1'b1));
      append_row(wr_row(255, 0, 1'b0));
      append_row(wr_row(0, 255, 1'b1));
      append_row(wr_row(170, 85, 1'b1));
      append_row(wr_row(85, 170, 1'b0));
      append_row(chk_row(255, 255, 0, 0, 1'b1, 1'b0));
      append_row(chk_row(0, 255, 255, 0, 1'b1, 1'b0));
      append_row(chk_row(85, 170, 170, 85, 1'b1, 1'b0));
      append_row(csr_row(CSR_MAP_WIDTH, 0));
      append_row(wr_row(200, 200, 1'b1));
      append_row(chk_row(100, 100, 110, 104, 1'b1, 1'b0));
      append_row(csr_row(CSR_MAP_WIDTH, 511));
      append_row(csr_row(CSR_MAP_HEIGHT, 0));
      append_row(chk_row(20, 200, 30, 190, 1'b1, 1'b0));
      append_row(csr_row(CSR_SPARE_A, 511));
      append_row(csr_row(CSR_SPARE_B, 341));
      append_row(csr_row(CSR_MAP_HEIGHT, 511));
      append_row(chk_row(6, 6, 6, 6, 1'b1, 1'b0));
      append_row(csr_row(CSR_MAP_WIDTH, 256));
      append_row(csr_row(CSR_MAP_HEIGHT, 256));
      append_row(wr_row(6, 6, 1'b1));
      append_row(chk_row(6, 6, 12, 3, 1'b0, 1'b0));

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (plan_rows[i]) begin
         if (plan_rows[i].kind == ROW_CSR)
            write_csr(plan_rows[i].csr_idx, plan_rows[i].csr_val);
         else
            send_cmd(plan_rows[i].cmd, plan_rows[i].known, plan_rows[i].answer);
      end

      // open a free patch, then probe it under full, saturated, cut and degenerate maps
      w0 = $urandom_range(14, 16);
      h0 = $urandom_range(14, 16);
      carve_region(edge_or_any(w0), edge_or_any(h0), w0, h0);
      run_mixed(80);

      write_csr(CSR_MAP_WIDTH, CSR_W'(511));
      write_csr(CSR_MAP_HEIGHT, CSR_W'(300));
      write_csr(CSR_SPARE_A, CSR_W'($urandom));
      run_mixed(40);

      write_csr(CSR_MAP_WIDTH, CSR_W'(reg_x + reg_w - 2));
      write_csr(CSR_MAP_HEIGHT, CSR_W'(reg_y + reg_h));
      run_mixed(40);

      write_csr(CSR_MAP_WIDTH, CSR_W'(0));
      write_csr(CSR_MAP_HEIGHT, CSR_W'($urandom_range(0, 511)));
      run_mixed(20);

      write_csr(CSR_MAP_WIDTH, CSR_W'(1));
      write_csr(CSR_MAP_HEIGHT, CSR_W'(1));
      run_mixed(20);

      // second patch against the far corner
      write_csr(CSR_MAP_WIDTH, CSR_W'(256));
      write_csr(CSR_MAP_HEIGHT, CSR_W'(256));
      w0 = $urandom_range(14, 15);
      h0 = $urandom_range(14, 15);
      carve_region(GRID_SIDE - w0, GRID_SIDE - h0, w0, h0);
      run_mixed(80);

      write_csr(CSR_MAP_WIDTH, CSR_W'($urandom_range(0, 511)));
      write_csr(CSR_MAP_HEIGHT, CSR_W'($urandom_range(0, 511)));
      write_csr(CSR_SPARE_B, CSR_W'($urandom));
      run_mixed(50);

      write_csr(CSR_MAP_WIDTH, CSR_W'(511));
      write_csr(CSR_MAP_HEIGHT, CSR_W'(511));
      run_mixed(50);

      @(negedge clock) start <= 1'b0;
      while (clear_expected.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/scc_pkg.sv
rtl/scc_grid.sv
rtl/segment_clearance_check_top.sv
rtl/scc_checker.sv
verif/tb_top.sv
